FILE: rtl/core/paas_pkg.sv
`default_nettype none

package paas_pkg;

    // Opcodes of an input item.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_RUN   = 2'd2,
        OP_ABORT = 2'd3
    } t_opcode;

    // Sequence phases. Codes ten to fifteen are unused and behave as disabled.
    typedef enum logic [3:0] {
        PH_DISABLED  = 4'd0,
        PH_WAKE      = 4'd1,
        PH_RETRACT   = 4'd2,
        PH_RET_STOP  = 4'd3,
        PH_SETTLE    = 4'd4,
        PH_PRE_FAST  = 4'd5,
        PH_FAST      = 4'd6,
        PH_PRE_SLOW  = 4'd7,
        PH_SLOW      = 4'd8,
        PH_REACHED   = 4'd9
    } t_phase;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SETPOINT   = 2'd0;
    localparam logic [1:0] CFG_RETRACT_MS = 2'd1;
    localparam logic [1:0] CFG_SETTLE_MS  = 2'd2;
    localparam logic [1:0] CFG_RATIO_PCT  = 2'd3;

    localparam logic [15:0] SETPOINT_RST   = 16'd0;
    localparam logic [15:0] RETRACT_MS_RST = 16'd200;
    localparam logic [15:0] SETTLE_MS_RST  = 16'd600;
    localparam logic [6:0]  RATIO_PCT_RST  = 7'd94;

    // Motor speed words.
    localparam logic [15:0] SPEED_FAST = 16'h66BC;
    localparam logic [15:0] SPEED_BACK = 16'h647D;
    localparam logic [15:0] SPEED_SLOW = 16'h4E20;

    localparam logic [15:0] MS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] setpoint;
        logic [15:0] retract_ms;
        logic [15:0] settle_ms;
        logic [6:0]  ratio_pct;
    } t_cfg;

    typedef struct packed {
        logic run;
        logic fwd;
        logic eighth;
        logic awake;
        logic pid;
    } t_drive;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] ms_count;
        logic [15:0] initial_level;
        logic [15:0] last_level;
        logic [15:0] motor_word;
        t_drive      drive;
    } t_state;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] level;
        logic        motor_running;
        logic        motor_forward;
        logic [15:0] motor_speed;
        logic        eighth_steps;
        logic        motor_awake;
        logic        pid_on;
        logic [1:0]  reports;
        logic        aborted;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/paas_in_if.sv
`default_nettype none

interface paas_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] sample;

    modport source (output valid, output opcode, output sample, input ready);
    modport sink   (input valid, input opcode, input sample, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/paas_out_if.sv
`default_nettype none

interface paas_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  phase;
    logic [15:0] level;
    logic        motor_running;
    logic        motor_forward;
    logic [15:0] motor_speed;
    logic        eighth_steps;
    logic        motor_awake;
    logic        pid_on;
    logic [1:0]  reports;
    logic        aborted;

    modport source (
        output valid, output phase, output level, output motor_running,
        output motor_forward, output motor_speed, output eighth_steps,
        output motor_awake, output pid_on, output reports, output aborted,
        input  ready
    );
    modport sink (
        input  valid, input phase, input level, input motor_running,
        input  motor_forward, input motor_speed, input eighth_steps,
        input  motor_awake, input pid_on, input reports, input aborted,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/paas_cfg.sv
`default_nettype none

module paas_cfg
    import paas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint   <= SETPOINT_RST;
            r_cfg.retract_ms <= RETRACT_MS_RST;
            r_cfg.settle_ms  <= SETTLE_MS_RST;
            r_cfg.ratio_pct  <= RATIO_PCT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SETPOINT:   r_cfg.setpoint   <= i_cfg_data;
                CFG_RETRACT_MS: r_cfg.retract_ms <= i_cfg_data;
                CFG_SETTLE_MS:  r_cfg.settle_ms  <= i_cfg_data;
                CFG_RATIO_PCT:  r_cfg.ratio_pct  <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/core/paas_step.sv
`default_nettype none

module paas_step
    import paas_pkg::*;
(
    input  wire t_opcode     i_op,
    input  wire logic [15:0] i_sample,
    input  wire t_cfg        i_cfg,
    input  wire t_state      i_state,
    output t_state           o_state,
    output t_result          o_result
);

    t_phase      n_phase;
    logic [15:0] n_ms_count;
    logic [15:0] n_initial_level;
    logic [15:0] n_last_level;
    logic [15:0] n_motor_word;
    t_drive      n_drive;
    logic [1:0]  w_reports;
    logic        w_aborted;

    logic [15:0] w_ratio_x;
    logic [22:0] w_ratio_lhs;
    logic [22:0] w_ratio_rhs;
    logic        w_at_ratio;
    logic        w_at_setpoint;
    logic        w_ms_retract_done;
    logic        w_ms_settle_done;

    // Pre-fast tests the setpoint against the ratio; fast approach tests the sample.
    assign w_ratio_x   = (i_state.phase == PH_PRE_FAST) ? i_cfg.setpoint : i_sample;
    assign w_ratio_lhs = 23'(w_ratio_x) * 23'd100;
    assign w_ratio_rhs = 23'(i_cfg.ratio_pct) * 23'(i_state.initial_level);
    assign w_at_ratio  = (w_ratio_lhs <= w_ratio_rhs);

    assign w_at_setpoint     = (i_sample <= i_cfg.setpoint);
    assign w_ms_retract_done = (i_state.ms_count >= i_cfg.retract_ms);
    assign w_ms_settle_done  = (i_state.ms_count >= i_cfg.settle_ms);

    // Next phase.
    always_comb begin
        n_phase = i_state.phase;
        unique case (i_op)
            OP_START: n_phase = PH_WAKE;
            OP_TICK:  n_phase = i_state.phase;
            OP_ABORT: n_phase = PH_DISABLED;
            OP_RUN: begin
                unique case (i_state.phase)
                    PH_WAKE:     n_phase = PH_RETRACT;
                    PH_RETRACT:  n_phase = w_ms_retract_done ? PH_RET_STOP : PH_RETRACT;
                    PH_RET_STOP: n_phase = PH_SETTLE;
                    PH_SETTLE:   n_phase = w_ms_settle_done ? PH_PRE_FAST : PH_SETTLE;
                    PH_PRE_FAST: begin
                        if (w_at_setpoint) begin
                            n_phase = PH_REACHED;
                        end else if (w_at_ratio) begin
                            n_phase = PH_FAST;
                        end else begin
                            n_phase = PH_PRE_SLOW;
                        end
                    end
                    PH_FAST:     n_phase = w_at_ratio ? PH_PRE_SLOW : PH_FAST;
                    PH_PRE_SLOW: n_phase = w_at_setpoint ? PH_REACHED : PH_SLOW;
                    PH_SLOW:     n_phase = w_at_setpoint ? PH_REACHED : PH_SLOW;
                    default:     n_phase = PH_DISABLED;
                endcase
            end
            default: n_phase = i_state.phase;
        endcase
    end

    // Data path and result fields.
    always_comb begin
        n_ms_count      = i_state.ms_count;
        n_initial_level = i_state.initial_level;
        n_last_level    = i_state.last_level;
        n_motor_word    = i_state.motor_word;
        n_drive         = i_state.drive;
        w_reports       = 2'd0;
        w_aborted       = 1'b0;
        unique case (i_op)
            OP_START: n_ms_count = 16'd0;
            OP_TICK: begin
                if (i_state.ms_count != MS_MAX) begin
                    n_ms_count = i_state.ms_count + 16'd1;
                end
            end
            OP_ABORT: w_aborted = 1'b1;
            OP_RUN: begin
                unique case (i_state.phase)
                    PH_WAKE: begin
                        n_last_level    = i_sample;
                        n_initial_level = 16'd0;
                        n_drive         = '{run: 1'b1, fwd: 1'b1, eighth: 1'b0,
                                            awake: 1'b1, pid: 1'b0};
                        n_motor_word    = SPEED_FAST;
                        w_reports       = 2'd1;
                        n_ms_count      = 16'd0;
                    end
                    PH_RETRACT: begin
                        if (w_ms_retract_done) w_reports = 2'd1;
                    end
                    PH_RET_STOP: begin
                        n_drive.run     = 1'b0;
                        n_drive.fwd     = 1'b0;
                        n_motor_word    = SPEED_BACK;
                        n_last_level    = i_sample;
                        n_initial_level = i_sample;
                        w_reports       = 2'd1;
                        n_ms_count      = 16'd0;
                    end
                    PH_SETTLE: begin
                        if (w_ms_settle_done) w_reports = 2'd1;
                    end
                    PH_PRE_FAST: begin
                        n_last_level = i_sample;
                        if (!w_at_setpoint && w_at_ratio) begin
                            n_drive.run = 1'b1;
                            w_reports   = 2'd1;
                            n_ms_count  = 16'd0;
                        end
                    end
                    PH_FAST: begin
                        n_last_level = i_sample;
                        if (w_at_ratio) w_reports = 2'd1;
                    end
                    PH_PRE_SLOW: begin
                        // The slow check runs on the same sample, so two reports can result.
                        n_drive.eighth = 1'b1;
                        n_drive.run    = !w_at_setpoint;
                        n_motor_word   = SPEED_SLOW;
                        n_last_level   = i_sample;
                        w_reports      = w_at_setpoint ? 2'd2 : 2'd1;
                    end
                    PH_SLOW: begin
                        n_last_level = i_sample;
                        if (w_at_setpoint) begin
                            n_drive.run = 1'b0;
                            w_reports   = 2'd1;
                        end
                    end
                    PH_REACHED: begin
                        n_drive.run   = 1'b0;
                        n_drive.awake = 1'b0;
                        n_drive.pid   = 1'b1;
                        w_reports     = 2'd2;
                    end
                    default: begin
                        n_drive.run   = 1'b0;
                        n_drive.awake = 1'b0;
                        w_reports     = 2'd1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        o_state.phase         = n_phase;
        o_state.ms_count      = n_ms_count;
        o_state.initial_level = n_initial_level;
        o_state.last_level    = n_last_level;
        o_state.motor_word    = n_motor_word;
        o_state.drive         = n_drive;

        o_result.phase         = n_phase;
        o_result.level         = n_last_level;
        o_result.motor_running = n_drive.run;
        o_result.motor_forward = n_drive.fwd;
        o_result.motor_speed   = n_motor_word;
        o_result.eighth_steps  = n_drive.eighth;
        o_result.motor_awake   = n_drive.awake;
        o_result.pid_on        = n_drive.pid;
        o_result.reports       = w_reports;
        o_result.aborted       = w_aborted;
    end

endmodule

`default_nettype wire

FILE: rtl/core/probe_auto_approach_sequencer.sv
// Channel   Direction  Handshake          Payload
// i_in      in         valid / ready      opcode[1:0], sample[15:0]
// o_out     out        valid / ready      phase, level, motor flags, speed, reports, aborted
// cfg       in         i_cfg_we           i_cfg_idx[1:0], i_cfg_data[15:0]
//
// One item per cycle sustained while o_out is not stalled; every item gives one result,
// registered first in the input register, then through the step logic into the result register.
// The sequencer state is updated in the same cycle as the result register loads, so
// back-to-back items see the state left by the one before.
// i_rst_n is synchronous and active low; it clears the state and the valid flags.
// A stalled output holds its result; the input register keeps taking items as long as
// the result register is free or is being emptied in that cycle.
`default_nettype none

module probe_auto_approach_sequencer
    import paas_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    paas_in_if.sink          i_in,
    paas_out_if.source       o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg        w_cfg;
    t_state      r_state;
    t_state      w_state_next;
    t_result     w_result;
    t_result     r_out;
    logic        r_out_valid;
    logic        r_in_valid;
    logic [1:0]  r_in_op;
    logic [15:0] r_in_sample;
    logic        w_fire;

    paas_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    paas_step u_step (
        .i_op     (t_opcode'(r_in_op)),
        .i_sample (r_in_sample),
        .i_cfg    (w_cfg),
        .i_state  (r_state),
        .o_state  (w_state_next),
        .o_result (w_result)
    );

    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op     <= i_in.opcode;
            r_in_sample <= i_in.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_DISABLED;
            r_state.ms_count      <= 16'd0;
            r_state.initial_level <= 16'd0;
            r_state.last_level    <= 16'd0;
            r_state.motor_word    <= 16'd0;
            r_state.drive         <= '0;
        end else if (w_fire) begin
            r_state <= w_state_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.phase         = r_out.phase;
    assign o_out.level         = r_out.level;
    assign o_out.motor_running = r_out.motor_running;
    assign o_out.motor_forward = r_out.motor_forward;
    assign o_out.motor_speed   = r_out.motor_speed;
    assign o_out.eighth_steps  = r_out.eighth_steps;
    assign o_out.motor_awake   = r_out.motor_awake;
    assign o_out.pid_on        = r_out.pid_on;
    assign o_out.reports       = r_out.reports;
    assign o_out.aborted       = r_out.aborted;

endmodule

`default_nettype wire

FILE: rtl/core/paas_checker.sv
`default_nettype none

module paas_checker
    import paas_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [3:0] i_out_phase,
    input wire logic       i_out_motor_running,
    input wire logic [1:0] i_out_reports,
    input wire logic       i_out_aborted
);

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_phase)
            && $stable(i_out_reports) && $stable(i_out_aborted))
        else $error("output item changed while stalled");

    // An abort leaves the sequence disabled and sends no report.
    a_abort_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_aborted |-> i_out_phase == PH_DISABLED && i_out_reports == 2'd0)
        else $error("abort item with wrong phase or reports");

    // On reaching the setpoint the motor is stopped.
    a_reached_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_phase == PH_REACHED |-> !i_out_motor_running)
        else $error("motor running at setpoint");

    // Two reports come only with arrival at the setpoint or the step after it.
    a_two_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_reports == 2'd2
            |-> i_out_phase == PH_REACHED || i_out_phase == PH_DISABLED)
        else $error("double report in an unexpected phase");

endmodule

bind probe_auto_approach_sequencer paas_checker u_paas_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_phase         (o_out.phase),
    .i_out_motor_running (o_out.motor_running),
    .i_out_reports       (o_out.reports),
    .i_out_aborted       (o_out.aborted)
);

`default_nettype wire

FILE: tb/sv/tb_probe_auto_approach_sequencer.sv
`default_nettype none

module tb_probe_auto_approach_sequencer;
    import paas_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned RANDOM_ITEMS = 880;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    paas_in_if  in_ch();
    paas_out_if out_ch();

    probe_auto_approach_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the sequencer state and its registers, advanced on every accepted item.
    t_cfg        seq_cfg = '{setpoint: SETPOINT_RST, retract_ms: RETRACT_MS_RST,
                             settle_ms: SETTLE_MS_RST, ratio_pct: RATIO_PCT_RST};
    t_phase      seq_phase = PH_DISABLED;
    logic [15:0] seq_ms = '0;
    logic [15:0] seq_initial = '0;
    logic [15:0] seq_level = '0;
    logic [15:0] seq_speed = '0;
    t_drive      seq_drive = '0;

    t_result     pending_status[$];
    t_result     status_want;
    int unsigned error_count = 0;
    int unsigned result_count = 0;
    int unsigned items_sent = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;

    function automatic bit within_ratio(logic [15:0] x);
        int unsigned lhs;
        int unsigned rhs;
        lhs = 32'(x) * 100;
        rhs = 32'(seq_cfg.ratio_pct) * 32'(seq_initial);
        return lhs <= rhs;
    endfunction

    function automatic t_result advance_approach(t_opcode op, logic [15:0] smp);
        t_result    r;
        logic [1:0] rep;
        logic       ab;
        rep = 2'd0;
        ab  = 1'b0;
        case (op)
            OP_START: begin
                seq_phase = PH_WAKE;
                seq_ms    = '0;
            end
            OP_TICK: begin
                if (seq_ms != MS_MAX) seq_ms = seq_ms + 16'd1;
            end
            OP_ABORT: begin
                seq_phase = PH_DISABLED;
                ab        = 1'b1;
            end
            default: begin
                case (seq_phase)
                    PH_WAKE: begin
                        seq_level   = smp;
                        seq_initial = '0;
                        seq_drive   = '{run: 1'b1, fwd: 1'b1, eighth: 1'b0,
                                        awake: 1'b1, pid: 1'b0};
                        seq_speed   = SPEED_FAST;
                        rep         = 2'd1;
                        seq_phase   = PH_RETRACT;
                        seq_ms      = '0;
                    end
                    PH_RETRACT: begin
                        if (seq_ms >= seq_cfg.retract_ms) begin
                            rep       = 2'd1;
                            seq_phase = PH_RET_STOP;
                        end
                    end
                    PH_RET_STOP: begin
                        seq_drive.run = 1'b0;
                        seq_drive.fwd = 1'b0;
                        seq_speed     = SPEED_BACK;
                        seq_level     = smp;
                        seq_initial   = smp;
                        rep           = 2'd1;
                        seq_phase     = PH_SETTLE;
                        seq_ms        = '0;
                    end
                    PH_SETTLE: begin
                        if (seq_ms >= seq_cfg.settle_ms) begin
                            rep       = 2'd1;
                            seq_phase = PH_PRE_FAST;
                        end
                    end
                    PH_PRE_FAST: begin
                        seq_level = smp;
                        if (smp <= seq_cfg.setpoint) begin
                            seq_phase = PH_REACHED;
                        end else if (within_ratio(seq_cfg.setpoint)) begin
                            seq_drive.run = 1'b1;
                            rep           = 2'd1;
                            seq_phase     = PH_FAST;
                            seq_ms        = '0;
                        end else begin
                            seq_phase = PH_PRE_SLOW;
                        end
                    end
                    PH_FAST: begin
                        seq_level = smp;
                        if (within_ratio(smp)) begin
                            rep       = 2'd1;
                            seq_phase = PH_PRE_SLOW;
                        end
                    end
                    PH_PRE_SLOW: begin
                        // The slow check is made on the same sample straight away.
                        seq_drive.eighth = 1'b1;
                        seq_drive.run    = 1'b1;
                        seq_speed        = SPEED_SLOW;
                        seq_level        = smp;
                        rep              = 2'd1;
                        seq_phase        = PH_SLOW;
                        if (smp <= seq_cfg.setpoint) begin
                            seq_drive.run = 1'b0;
                            rep           = 2'd2;
                            seq_phase     = PH_REACHED;
                        end
                    end
                    PH_SLOW: begin
                        seq_level = smp;
                        if (smp <= seq_cfg.setpoint) begin
                            seq_drive.run = 1'b0;
                            rep           = 2'd1;
                            seq_phase     = PH_REACHED;
                        end
                    end
                    PH_REACHED: begin
                        seq_drive.run   = 1'b0;
                        seq_drive.awake = 1'b0;
                        seq_drive.pid   = 1'b1;
                        rep             = 2'd2;
                        seq_phase       = PH_DISABLED;
                    end
                    default: begin
                        seq_drive.run   = 1'b0;
                        seq_drive.awake = 1'b0;
                        seq_phase       = PH_DISABLED;
                        rep             = 2'd1;
                    end
                endcase
            end
        endcase
        r.phase         = seq_phase;
        r.level         = seq_level;
        r.motor_running = seq_drive.run;
        r.motor_forward = seq_drive.fwd;
        r.motor_speed   = seq_speed;
        r.eighth_steps  = seq_drive.eighth;
        r.motor_awake   = seq_drive.awake;
        r.pid_on        = seq_drive.pid;
        r.reports       = rep;
        r.aborted       = ab;
        return r;
    endfunction

    function automatic logic [15:0] clip16(int v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return 16'(v);
    endfunction

    task automatic flag_error(input string line);
        $display("mismatch: %s", line);
        error_count++;
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            flag_error($sformatf("result %0d %s got %h want %h", result_count, name, got, want));
    endtask

    // Outputs are sampled mid-cycle, where they hold the values seen at the next rising edge.
    always @(negedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_status.size() == 0) begin
                flag_error($sformatf("result %0d arrived with nothing expected", result_count));
            end else begin
                status_want = pending_status.pop_front();
                compare_field("phase", out_ch.phase, status_want.phase);
                compare_field("level", out_ch.level, status_want.level);
                compare_field("motor_running", out_ch.motor_running, status_want.motor_running);
                compare_field("motor_forward", out_ch.motor_forward, status_want.motor_forward);
                compare_field("motor_speed", out_ch.motor_speed, status_want.motor_speed);
                compare_field("eighth_steps", out_ch.eighth_steps, status_want.eighth_steps);
                compare_field("motor_awake", out_ch.motor_awake, status_want.motor_awake);
                compare_field("pid_on", out_ch.pid_on, status_want.pid_on);
                compare_field("reports", out_ch.reports, status_want.reports);
                compare_field("aborted", out_ch.aborted, status_want.aborted);
            end
            result_count++;
        end
    end

    // The receiver switches between stall styles every so often.
    initial begin : receiver_stalls
        int unsigned stall_mode;
        int unsigned stall_run;
        stall_mode = 0;
        stall_run  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_run == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_run  = $urandom_range(16, 200);
            end
            stall_run--;
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       out_ch.ready <= ($urandom_range(0, 9) < 3);
                default: out_ch.ready <= (stall_run % 8) >= 5;
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_probe_auto_approach_sequencer: errors");
            $finish;
        end
    end

    task automatic send_item(input t_opcode op, input logic [15:0] smp);
        bit took;
        if (!steady && burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.sample <= smp;
        do begin
            @(negedge i_clk);
            took = in_ch.ready;
            @(posedge i_clk);
        end while (!took);
        pending_status.push_back(advance_approach(op, smp));
        if (burst_left > 0) burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_status.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SETPOINT:   seq_cfg.setpoint   = data;
            CFG_RETRACT_MS: seq_cfg.retract_ms = data;
            CFG_SETTLE_MS:  seq_cfg.settle_ms  = data;
            default:        seq_cfg.ratio_pct  = data[6:0];
        endcase
    endtask

    task automatic configure(input logic [15:0] sp, input logic [15:0] retract,
                             input logic [15:0] settle, input logic [6:0] pct);
        wait_drained();
        write_register(CFG_SETPOINT, sp);
        write_register(CFG_RETRACT_MS, retract);
        write_register(CFG_SETTLE_MS, settle);
        write_register(CFG_RATIO_PCT, {9'd0, pct});
    endtask

    // Whole approach through retract, settle, fast and slow phases, with samples
    // on both sides of the ratio boundary.
    task automatic test_full_approach();
        configure(16'd1000, 16'd1, 16'd2, 7'd94);
        send_item(OP_START, 16'h0000);
        send_item(OP_RUN, 16'h1234);
        send_item(OP_RUN, 16'h0000);
        send_item(OP_TICK, 16'hFFFF);
        send_item(OP_RUN, 16'h5555);
        send_item(OP_RUN, 16'hFFFF);
        send_item(OP_TICK, 16'hAAAA);
        send_item(OP_RUN, 16'h0001);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_RUN, 16'h8000);
        send_item(OP_RUN, 16'd50000);
        send_item(OP_RUN, 16'd61603);
        send_item(OP_RUN, 16'd61602);
        send_item(OP_RUN, 16'd2000);
        send_item(OP_RUN, 16'd1000);
        send_item(OP_RUN, 16'h7FFF);
        send_item(OP_ABORT, 16'hFFFF);
    endtask

    // Zero durations and the top setpoint: the first approach sample already ends it.
    task automatic test_direct_reach();
        configure(MS_MAX, 16'd0, 16'd0, 7'd100);
        send_item(OP_START, 16'hFFFF);
        send_item(OP_RUN, 16'hFFFF);
        send_item(OP_RUN, 16'h0000);
        send_item(OP_RUN, 16'h0000);
        send_item(OP_RUN, 16'h0F0F);
        send_item(OP_RUN, 16'hFFFF);
        send_item(OP_ABORT, 16'h0000);
        send_item(OP_RUN, 16'h0000);
    endtask

    // Back-to-back ticks against the retract and settle thresholds, one short of
    // each and then exactly on it, and a restart clearing the count.
    task automatic test_tick_count();
        configure(16'd100, 16'd12, 16'd7, 7'd50);
        send_item(OP_START, 16'h0000);
        send_item(OP_RUN, 16'h4321);
        steady = 1'b1;
        repeat (11) send_item(OP_TICK, 16'($urandom));
        steady = 1'b0;
        send_item(OP_RUN, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_RUN, 16'h0000);
        send_item(OP_RUN, 16'd3000);
        steady = 1'b1;
        repeat (6) send_item(OP_TICK, 16'($urandom));
        steady = 1'b0;
        send_item(OP_RUN, 16'h0000);
        send_item(OP_TICK, 16'h0000);
        send_item(OP_RUN, 16'h0000);
        send_item(OP_RUN, 16'hC000);
        send_item(OP_RUN, 16'd1500);
        send_item(OP_RUN, 16'h0000);
        send_item(OP_RUN, 16'h0000);
        send_item(OP_START, 16'h0000);
        send_item(OP_RUN, 16'h0000);
        send_item(OP_RUN, 16'h0000);
        send_item(OP_ABORT, 16'h0000);
    endtask

    // One item chosen to move the approach on from its present phase, with some noise.
    task automatic send_guided();
        t_opcode     op;
        logic [15:0] s;
        int unsigned r;
        int unsigned bound;
        r = $urandom_range(0, 99);
        s = 16'($urandom);
        op = OP_RUN;
        if (r < 12) begin
            op = t_opcode'($urandom_range(0, 3));
        end else begin
            case (seq_phase)
                PH_DISABLED: op = OP_START;
                PH_RETRACT:  op = (seq_ms >= seq_cfg.retract_ms || r < 25) ? OP_RUN : OP_TICK;
                PH_SETTLE:   op = (seq_ms >= seq_cfg.settle_ms || r < 25) ? OP_RUN : OP_TICK;
                PH_FAST: begin
                    bound = (32'(seq_cfg.ratio_pct) * 32'(seq_initial)) / 100;
                    case ($urandom_range(0, 2))
                        0: s = clip16(int'(bound) + int'($urandom_range(0, 4)) - 2);
                        1: s = 16'($urandom_range(0, seq_initial));
                        default: ;
                    endcase
                end
                PH_PRE_FAST, PH_PRE_SLOW, PH_SLOW: begin
                    case ($urandom_range(0, 4))
                        0, 1: s = clip16(int'(seq_cfg.setpoint) + int'($urandom_range(0, 16)) - 8);
                        2:    s = 16'($urandom_range(0, seq_cfg.setpoint));
                        default: ;
                    endcase
                end
                default: op = OP_RUN;
            endcase
        end
        send_item(op, s);
    endtask

    task automatic test_random_approaches();
        int unsigned first;
        logic [15:0] sp;
        logic [15:0] retract;
        logic [15:0] settle;
        logic [6:0]  pct;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       sp = 16'd0;
                1:       sp = MS_MAX;
                2:       sp = 16'($urandom);
                default: sp = 16'($urandom_range(0, 3000));
            endcase
            case ($urandom_range(0, 19))
                0:       retract = MS_MAX;
                1, 2:    retract = 16'($urandom_range(4, 12));
                default: retract = 16'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 19))
                0:       settle = MS_MAX;
                1, 2:    settle = 16'($urandom_range(4, 12));
                default: settle = 16'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 5))
                0:       pct = 7'd0;
                1:       pct = 7'd100;
                default: pct = 7'($urandom_range(0, 100));
            endcase
            configure(sp, retract, settle, pct);
            repeat ($urandom_range(10, 45)) begin
                send_guided();
                if ($urandom_range(0, 49) == 0) wait_drained();
            end
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_SETPOINT;
        i_cfg_data   <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.opcode <= OP_TICK;
        in_ch.sample <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_approach();
        test_direct_reach();
        test_tick_count();
        test_random_approaches();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_probe_auto_approach_sequencer: clean");
        end else begin
            $display("tb_probe_auto_approach_sequencer: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/paas_pkg.sv
rtl/core/paas_in_if.sv
rtl/core/paas_out_if.sv
rtl/core/paas_cfg.sv
rtl/core/paas_step.sv
rtl/core/probe_auto_approach_sequencer.sv
rtl/core/paas_checker.sv
tb/sv/tb_probe_auto_approach_sequencer.sv
